>>> rtl/u8u16_pkg.sv
package u8u16_pkg;

	localparam logic [15:0] REPL_UNIT = 16'h003F;

	typedef enum logic [2:0] {
		CLS_ASCII,
		CLS_CONT,
		CLS_LEAD2,
		CLS_LEAD3,
		CLS_LEAD4,
		CLS_INVALID
	} byte_class_t;

	// one queue entry: up to two code units caused by one input byte
	typedef struct packed {
		logic [15:0] unit;
		logic        repl;
		logic        two;     // a replacement goes out ahead of unit
		logic        last;    // the byte closed the string
	} unit_entry_t;

	function automatic byte_class_t classify(input logic [7:0] b);
		byte_class_t cls;
		cls = CLS_INVALID;
		if (!b[7])
			cls = CLS_ASCII;
		else if (b[7:6] == 2'b10)
			cls = CLS_CONT;
		else if (b[7:5] == 3'b110)
			cls = CLS_LEAD2;
		else if (b[7:4] == 4'b1110)
			cls = CLS_LEAD3;
		else if (b[7:3] == 5'b11110)
			cls = CLS_LEAD4;
		return cls;
	endfunction

endpackage

>>> rtl/u8u16_front.sv
module u8u16_front
	import u8u16_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  in_byte,
	input  logic        string_end,
	output logic        push,
	output unit_entry_t push_data
);

	logic [1:0]  pending_q;
	logic [15:0] acc_q;
	logic [1:0]  pending_d;
	logic [15:0] acc_d;
	logic        has_res;
	byte_class_t cls;

	always_comb begin
		cls                = classify(in_byte);
		pending_d          = pending_q;
		acc_d              = acc_q;
		has_res            = 1'b0;
		push_data.unit     = REPL_UNIT;
		push_data.repl     = 1'b1;
		push_data.two      = 1'b0;
		push_data.last     = string_end;
		unique case (cls)
			CLS_ASCII: begin
				push_data.two  = (pending_q != 2'd0);
				push_data.unit = {8'h00, in_byte};
				push_data.repl = 1'b0;
				has_res        = 1'b1;
				pending_d      = 2'd0;
			end
			CLS_CONT: begin
				if (pending_q != 2'd0) begin
					acc_d     = {acc_q[9:0], in_byte[5:0]};
					pending_d = pending_q - 2'd1;
					if (pending_d == 2'd0) begin
						has_res        = 1'b1;
						push_data.unit = acc_d;
						push_data.repl = 1'b0;
					end
				end else begin
					has_res = 1'b1;
				end
			end
			CLS_LEAD2: begin
				pending_d = 2'd1;
				acc_d     = {11'd0, in_byte[4:0]};
			end
			CLS_LEAD3: begin
				pending_d = 2'd2;
				acc_d     = {12'd0, in_byte[3:0]};
			end
			CLS_LEAD4: begin
				pending_d = 2'd3;
				acc_d     = {13'd0, in_byte[2:0]};
			end
			default: begin
				has_res   = 1'b1;
				pending_d = 2'd0;
			end
		endcase
		// sequence cut short by the end of the string
		if (string_end && pending_d != 2'd0) begin
			has_res        = 1'b1;
			push_data.unit = REPL_UNIT;
			push_data.repl = 1'b1;
			pending_d      = 2'd0;
		end
	end

	assign push = accept & has_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
			acc_q     <= 16'd0;
		end else if (accept) begin
			pending_q <= pending_d;
			acc_q     <= acc_d;
		end
	end

endmodule

>>> rtl/u8u16_queue.sv
module u8u16_queue
	import u8u16_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  unit_entry_t push_data,
	input  logic        pop,
	output unit_entry_t pop_data,
	output logic        full,
	output logic        empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	unit_entry_t    mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

>>> rtl/u8u16_back.sv
module u8u16_back
	import u8u16_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        entry_valid,
	input  unit_entry_t entry,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] code_unit,
	output logic        is_replacement,
	output logic        run_last,
	output logic        string_done
);

	logic out_valid_q;
	logic second_q;    // leading replacement of a two-unit entry already sent
	logic load;
	logic lead_repl;

	assign load      = entry_valid && (!out_valid_q || out_ready);
	assign lead_repl = entry.two && !second_q;
	assign pop       = load && !lead_repl;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				second_q    <= lead_repl;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (lead_repl) begin
				code_unit      <= REPL_UNIT;
				is_replacement <= 1'b1;
				run_last       <= 1'b0;
				string_done    <= 1'b0;
			end else begin
				code_unit      <= entry.unit;
				is_replacement <= entry.repl;
				run_last       <= 1'b1;
				string_done    <= entry.last;
			end
		end
	end

endmodule

>>> rtl/utf8_to_utf16_unit_decoder.sv
// channel | valid    | ready     | payload
// input   | in_valid | in_ready  | in_byte, string_end
// output  | out_valid| out_ready | code_unit, is_replacement, run_last, string_done
//
// one byte is taken per cycle while the unit queue has room
// a byte's first code unit is written into the unit queue, then loaded into the output register once it is free
// a byte that yields two units holds the output register for two transactions
// lead and mid-sequence bytes yield nothing and leave the queue alone, unless string_end cuts them short
// arst_n clears the pending count, the accumulator, the queue and the output valid
module utf8_to_utf16_unit_decoder
	import u8u16_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        string_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] code_unit,
	output logic        is_replacement,
	output logic        run_last,
	output logic        string_done
);

	logic        accept;
	logic        push;
	logic        pop;
	logic        full;
	logic        empty;
	unit_entry_t push_data;
	unit_entry_t pop_data;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	u8u16_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.in_byte    (in_byte),
		.string_end (string_end),
		.push       (push),
		.push_data  (push_data)
	);

	u8u16_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (full),
		.empty     (empty)
	);

	u8u16_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.entry_valid    (!empty),
		.entry          (pop_data),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.code_unit      (code_unit),
		.is_replacement (is_replacement),
		.run_last       (run_last),
		.string_done    (string_done)
	);

endmodule
